// ===== src/dcf_pkg.sv =====
// Shared types, constants and helper functions for the DCF77 frame decoder.
// Used by dcf_fields, dcf_mac and dcf77_frame_decoder; no dependencies.
`default_nettype none

package dcf_pkg;

    localparam int FRAME_W = 59;
    localparam int ACC_W   = 32;
    localparam int DAY_W   = 16;
    localparam int K_W     = 9;

    // Multiplier constants used by the shared unit
    localparam logic [K_W-1:0] K_ONE   = 9'd1;
    localparam logic [K_W-1:0] K_YEAR  = 9'd365;
    localparam logic [K_W-1:0] K_HOURS = 9'd24;
    localparam logic [K_W-1:0] K_MINS  = 9'd60;

    // Frame bit positions
    localparam int POS_START  = 0;
    localparam int POS_CEST   = 17;
    localparam int POS_CET    = 18;
    localparam int POS_TSTART = 20;
    localparam int POS_MIN    = 21;
    localparam int POS_HOUR   = 29;
    localparam int POS_DAY    = 36;
    localparam int POS_MON    = 45;
    localparam int POS_YEAR   = 50;

    // Control for one pass of the shared multiply-add unit
    typedef struct packed {
        logic [K_W-1:0] k;
        logic           wrap16;
    } t_mac_ctl;

    // Decoded frame fields
    typedef struct packed {
        logic       ok;
        logic       dst;
        logic [7:0] year;
        logic [4:0] month;
        logic [5:0] day;
        logic [5:0] hour;
        logic [6:0] minute;
    } t_fields;

    // BCD sum with weights 1,2,4,8,10,20,40,80 (digits above 9 pass through)
    function automatic logic [7:0] bcd_value(input logic [7:0] v);
        logic [7:0] hi;
        hi = {4'd0, v[7:4]};
        return {4'd0, v[3:0]} + 8'((hi << 3) + (hi << 1));
    endfunction

    // Length of month m; months 8 and up are folded down by one
    function automatic logic [4:0] month_days(input logic [4:0] m,
                                              input logic [7:0] yr);
        logic [4:0] mm;
        mm = (m >= 5'd8) ? (m - 5'd1) : m;
        if (m == 5'd2)
            return (yr[1:0] == 2'd0) ? 5'd29 : 5'd28;
        return 5'd30 + {4'd0, mm[0]};
    endfunction

endpackage

`default_nettype wire

// ===== src/dcf_fields.sv =====
// Frame field decoder: checks markers and parity, extracts BCD fields.
// Depends on dcf_pkg.
`default_nettype none

module dcf_fields (
    input  wire logic [dcf_pkg::FRAME_W-1:0] i_frame,
    output dcf_pkg::t_fields                 o_fields
);

    logic par_min, par_hour, par_date;

    assign par_min  = ^i_frame[28:21];
    assign par_hour = ^i_frame[35:29];
    assign par_date = ^i_frame[58:36];

    always_comb begin
        o_fields.ok = !i_frame[dcf_pkg::POS_START] && i_frame[dcf_pkg::POS_TSTART]
                   && (i_frame[dcf_pkg::POS_CEST] != i_frame[dcf_pkg::POS_CET])
                   && !par_min && !par_hour && !par_date;
        o_fields.dst    = i_frame[dcf_pkg::POS_CEST];
        o_fields.year   = dcf_pkg::bcd_value(i_frame[57:50]);
        o_fields.month  = 5'(dcf_pkg::bcd_value({3'd0, i_frame[49:45]}));
        o_fields.day    = 6'(dcf_pkg::bcd_value({2'd0, i_frame[41:36]}));
        o_fields.hour   = 6'(dcf_pkg::bcd_value({2'd0, i_frame[34:29]}));
        o_fields.minute = 7'(dcf_pkg::bcd_value({1'b0, i_frame[27:21]}));
    end

endmodule

`default_nettype wire

// ===== src/dcf_mac.sv =====
// Shared multiply-add unit: y = a * k + b, optionally wrapped to 16 bits.
// Depends on dcf_pkg.
`default_nettype none

module dcf_mac (
    input  wire logic [dcf_pkg::ACC_W-1:0] i_a,
    input  wire logic [dcf_pkg::ACC_W-1:0] i_b,
    input  wire dcf_pkg::t_mac_ctl         i_ctl,
    output logic [dcf_pkg::ACC_W-1:0]      o_y
);

    logic [dcf_pkg::ACC_W-1:0] prod;
    logic [dcf_pkg::ACC_W-1:0] sum;

    assign prod = i_a * {{(dcf_pkg::ACC_W-dcf_pkg::K_W){1'b0}}, i_ctl.k};
    assign sum  = prod + i_b;
    assign o_y  = i_ctl.wrap16
                ? {{(dcf_pkg::ACC_W-dcf_pkg::DAY_W){1'b0}}, sum[dcf_pkg::DAY_W-1:0]}
                : sum;

endmodule

`default_nettype wire

// ===== src/dcf77_frame_decoder.sv =====
// DCF77 minute frame decoder top level: sequencer around one multiply-add unit.
// Depends on dcf_pkg, dcf_fields and dcf_mac.
`default_nettype none

// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+---------------------------------
// frame    | in        | i_frame_valid/o_frame_stall | i_frame_bits[58:0]
// result   | out       | o_res_valid/i_res_stall     | o_frame_ok, o_minutes_since_epoch[31:0]
//
// A result is valid after states YEAR, MONTH, DAY, HOUR, MIN and DONE; MONTH loops
// once per previous month through the shared multiply-add unit, and DONE waits while
// the output is full and stalled. The next frame can be taken as the result turns valid.
// Reset (synchronous, active low) returns the sequencer to idle, empties the result.
// o_frame_stall is high while a frame is being worked on. A finished result sits in
// the output register; the next frame may be taken while it waits on i_res_stall.

module dcf77_frame_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_frame_valid,
    output logic             o_frame_stall,
    input  wire logic [58:0] i_frame_bits,
    output logic             o_res_valid,
    input  wire logic        i_res_stall,
    output logic             o_frame_ok,
    output logic [31:0]      o_minutes_since_epoch
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_YEAR  = 3'd1;
    localparam logic [2:0] S_MONTH = 3'd2;
    localparam logic [2:0] S_DAY   = 3'd3;
    localparam logic [2:0] S_HOUR  = 3'd4;
    localparam logic [2:0] S_MIN   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]                        r_state, n_state;
    logic [dcf_pkg::FRAME_W-1:0]       r_frame;
    logic [dcf_pkg::ACC_W-1:0]         r_acc, n_acc;
    logic [4:0]                        r_mon_idx, n_mon_idx;
    logic                              r_out_valid, n_out_valid;
    logic                              r_out_ok;
    logic [dcf_pkg::ACC_W-1:0]         r_out_mins;

    dcf_pkg::t_fields                  fields;
    dcf_pkg::t_mac_ctl                 mac_ctl;
    logic [dcf_pkg::ACC_W-1:0]         mac_a, mac_b, mac_y;
    logic                              frame_xfer, res_xfer, load_out;

    dcf_fields u_fields (
        .i_frame  (r_frame),
        .o_fields (fields)
    );

    dcf_mac u_mac (
        .i_a   (mac_a),
        .i_b   (mac_b),
        .i_ctl (mac_ctl),
        .o_y   (mac_y)
    );

    assign o_frame_stall = (r_state != S_IDLE);
    assign frame_xfer    = i_frame_valid && !o_frame_stall;
    assign res_xfer      = r_out_valid && !i_res_stall;
    // Result moves to the output register once it is empty or being drained
    assign load_out      = (r_state == S_DONE) && (!r_out_valid || !i_res_stall);

    // Operand selection for the shared unit
    always_comb begin
        mac_a          = r_acc;
        mac_b          = '0;
        mac_ctl.k      = dcf_pkg::K_ONE;
        mac_ctl.wrap16 = 1'b1;
        case (r_state)
            S_YEAR: begin
                // year * 365 + leap days before this year
                mac_a     = {24'd0, fields.year};
                mac_b     = {22'd0, 10'({2'd0, fields.year} + 10'd3) >> 2};
                mac_ctl.k = dcf_pkg::K_YEAR;
            end
            S_MONTH: begin
                mac_b = {27'd0, dcf_pkg::month_days(r_mon_idx, fields.year)};
            end
            S_DAY: begin
                mac_b = {26'd0, fields.day} - 32'd1;
            end
            S_HOUR: begin
                mac_b          = {26'd0, fields.hour} - {31'd0, fields.dst};
                mac_ctl.k      = dcf_pkg::K_HOURS;
                mac_ctl.wrap16 = 1'b0;
            end
            S_MIN: begin
                mac_b          = {25'd0, fields.minute};
                mac_ctl.k      = dcf_pkg::K_MINS;
                mac_ctl.wrap16 = 1'b0;
            end
            default: begin
                mac_b = '0;
            end
        endcase
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_mon_idx   = r_mon_idx;
        n_out_valid = r_out_valid;
        if (res_xfer) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (frame_xfer) begin
                    n_state = S_YEAR;
                end
            end
            S_YEAR: begin
                n_acc     = mac_y;
                n_mon_idx = 5'd1;
                n_state   = S_MONTH;
            end
            S_MONTH: begin
                // add lengths of months 1 .. month-1; month zero adds nothing
                if (r_mon_idx < fields.month) begin
                    n_acc     = mac_y;
                    n_mon_idx = r_mon_idx + 5'd1;
                end else begin
                    n_state = S_DAY;
                end
            end
            S_DAY: begin
                n_acc   = mac_y;
                n_state = S_HOUR;
            end
            S_HOUR: begin
                n_acc   = mac_y;
                n_state = S_MIN;
            end
            S_MIN: begin
                n_acc   = mac_y;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (load_out) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc     <= n_acc;
        r_mon_idx <= n_mon_idx;
        if (frame_xfer) begin
            r_frame <= i_frame_bits;
        end
        if (load_out) begin
            r_out_ok   <= fields.ok;
            r_out_mins <= r_acc;
        end
    end

    assign o_res_valid           = r_out_valid;
    assign o_frame_ok            = r_out_ok;
    assign o_minutes_since_epoch = r_out_mins;

endmodule

`default_nettype wire

// ===== tb/dcf77_decode_checker.sv =====
// Checker for the DCF77 frame decoder: watches both channels, predicts each decode
// and compares it with the result transfer. Depends on dcf_pkg for bit positions.
`timescale 1ns / 1ps

module dcf77_decode_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_frame_valid,
    input  wire logic        i_frame_stall,
    input  wire logic [58:0] i_frame_bits,
    input  wire logic        i_res_valid,
    input  wire logic        i_res_stall,
    input  wire logic        i_frame_ok,
    input  wire logic [31:0] i_minutes,
    output int               o_errors,
    output int               o_results,
    output int               o_outstanding
);

    typedef struct packed {
        logic        ok;
        logic [31:0] mins;
    } t_frame_decode;

    t_frame_decode pending_decodes[$];
    t_frame_decode want;
    int            mismatches   = 0;
    int            result_count = 0;

    // Weighted digit sum: 1,2,4,8 then 10,20,40,80; digits above 9 are not clamped
    function automatic int unsigned weigh_bcd(input logic [58:0] f, input int lsb,
                                              input int len);
        int unsigned acc;
        acc = 0;
        for (int k = 0; k < len; k++)
            if (f[lsb + k])
                acc += (k < 4) ? (1 << k) : (10 << (k - 4));
        return acc;
    endfunction

    function automatic int unsigned month_length(input int unsigned m,
                                                 input int unsigned yr);
        int unsigned folded;
        folded = m;
        if (m == 2)
            return (yr % 4 == 0) ? 29 : 28;
        if (folded >= 8)
            folded--;
        return 30 + (folded & 1);
    endfunction

    function automatic t_frame_decode decode_frame(input logic [58:0] f);
        t_frame_decode r;
        int unsigned   yr;
        int unsigned   mon;
        logic [15:0]   days;
        logic [31:0]   hrs;
        r.ok = !f[dcf_pkg::POS_START] && f[dcf_pkg::POS_TSTART]
               && (f[dcf_pkg::POS_CEST] != f[dcf_pkg::POS_CET])
               && !(^f[28:dcf_pkg::POS_MIN]) && !(^f[35:dcf_pkg::POS_HOUR])
               && !(^f[58:dcf_pkg::POS_DAY]);
        yr   = weigh_bcd(f, dcf_pkg::POS_YEAR, 8);
        mon  = weigh_bcd(f, dcf_pkg::POS_MON, 5);
        days = 16'(yr * 365 + (yr + 3) / 4);
        // month zero simply skips this loop
        for (int unsigned m = 1; m < mon; m++)
            days = days + 16'(month_length(m, yr));
        days = days + 16'(weigh_bcd(f, dcf_pkg::POS_DAY, 6)) - 16'd1;
        hrs  = 32'(days) * 32'd24 + 32'(weigh_bcd(f, dcf_pkg::POS_HOUR, 6))
               - 32'(f[dcf_pkg::POS_CEST]);
        r.mins = hrs * 32'd60 + 32'(weigh_bcd(f, dcf_pkg::POS_MIN, 7));
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pending_decodes.delete();
        end else begin
            if (i_frame_valid && !i_frame_stall)
                pending_decodes.push_back(decode_frame(i_frame_bits));
            if (i_res_valid && !i_res_stall) begin
                result_count++;
                if (pending_decodes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result %0d with no frame outstanding (ok=%0b min=%0d)",
                                 $realtime, result_count, i_frame_ok, i_minutes);
                end else begin
                    want = pending_decodes.pop_front();
                    if (want.ok !== i_frame_ok || want.mins !== i_minutes) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: result %0d: ok exp %0b got %0b, min exp %0d got %0d",
                                     $realtime, result_count, want.ok, i_frame_ok,
                                     want.mins, i_minutes);
                    end
                end
            end
        end
        o_errors      <= mismatches;
        o_results     <= result_count;
        o_outstanding <= pending_decodes.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// Top of the DCF77 frame decoder testbench: clock, reset, frame stimulus, result
// backpressure and verdict. Depends on dcf_pkg, dcf77_frame_decoder, dcf77_decode_checker.
`timescale 1ns / 1ps

module tb_top;

    localparam int HOLD_CYCLES = 400;  // long result hold-off, fills the decoder
    localparam int PHASE_ITEMS = 200;  // random frames per pacing phase
    localparam int DRAIN_WAIT  = 64;   // window after the last drain, longer than the slowest decode

    logic        i_clk;
    logic        i_rst_n;
    logic        i_frame_valid;
    logic        o_frame_stall;
    logic [58:0] i_frame_bits;
    logic        o_res_valid;
    logic        i_res_stall;
    logic        o_frame_ok;
    logic [31:0] o_minutes_since_epoch;

    int chk_errors;
    int chk_results;
    int chk_outstanding;

    // Pacing knobs, percent of cycles; set by the stimulus, read by both drivers
    int   tx_idle_pct  = 18;
    int   rx_stall_pct = 81;
    logic hold_req     = 1'b0;
    int   hold_left    = 0;
    int   n_sent       = 0;
    int   n_directed   = 0;

    dcf77_frame_decoder i_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_frame_valid         (i_frame_valid),
        .o_frame_stall         (o_frame_stall),
        .i_frame_bits          (i_frame_bits),
        .o_res_valid           (o_res_valid),
        .i_res_stall           (i_res_stall),
        .o_frame_ok            (o_frame_ok),
        .o_minutes_since_epoch (o_minutes_since_epoch)
    );

    dcf77_decode_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame_valid (i_frame_valid),
        .i_frame_stall (o_frame_stall),
        .i_frame_bits  (i_frame_bits),
        .i_res_valid   (o_res_valid),
        .i_res_stall   (i_res_stall),
        .i_frame_ok    (o_frame_ok),
        .i_minutes     (o_minutes_since_epoch),
        .o_errors      (chk_errors),
        .o_results     (chk_results),
        .o_outstanding (chk_outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: random stall per cycle, or a long counted hold when asked for.
    initial begin
        i_res_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                i_res_stall <= 1'b1;
                hold_left--;
            end else begin
                i_res_stall <= ($urandom_range(99) < rx_stall_pct);
            end
        end
    end

    function automatic logic [7:0] to_bcd(input int unsigned v);
        return 8'(((v / 10) << 4) | (v % 10));
    endfunction

    // Builds a frame with correct markers and parity from raw field bits; the
    // unused seconds (weather, call bit, announcements, weekday) come from noise.
    function automatic logic [58:0] make_frame(input logic [7:0] yr, input logic [4:0] mon,
                                               input logic [5:0] dom, input logic [5:0] hr,
                                               input logic [6:0] mi, input logic dst,
                                               input logic [58:0] noise);
        logic [58:0] f;
        f                         = noise;
        f[dcf_pkg::POS_START]     = 1'b0;
        f[dcf_pkg::POS_CEST]      = dst;
        f[dcf_pkg::POS_CET]       = ~dst;
        f[dcf_pkg::POS_TSTART]    = 1'b1;
        f[dcf_pkg::POS_MIN +: 7]  = mi;
        f[28]                     = ^mi;
        f[dcf_pkg::POS_HOUR +: 6] = hr;
        f[35]                     = ^hr;
        f[dcf_pkg::POS_DAY +: 6]  = dom;
        f[dcf_pkg::POS_MON +: 5]  = mon;
        f[dcf_pkg::POS_YEAR +: 8] = yr;
        f[58]                     = ^f[57:dcf_pkg::POS_DAY];
        return f;
    endfunction

    function automatic logic [58:0] rand_bits();
        return 59'({$urandom(), $urandom()});
    endfunction

    function automatic logic [58:0] legal_frame();
        return make_frame(to_bcd($urandom_range(99)), 5'(to_bcd($urandom_range(1, 12))),
                          6'(to_bcd($urandom_range(1, 31))), 6'(to_bcd($urandom_range(23))),
                          7'(to_bcd($urandom_range(59))), 1'($urandom_range(1)), rand_bits());
    endfunction

    // One frame transfer. Called at a clock edge; returns at the edge it was taken.
    // Valid is only dropped when an idle gap is inserted, never dropped and raised
    // in the same step.
    task automatic send_frame(input logic [58:0] f);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_frame_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_frame_valid <= 1'b1;
        i_frame_bits  <= f;
        do @(posedge i_clk); while (o_frame_stall);
        n_sent++;
    endtask

    // Sender goes quiet until every frame sent so far has its result back
    task automatic drain();
        i_frame_valid <= 1'b0;
        while (chk_results < n_sent)
            @(posedge i_clk);
    endtask

    task automatic send_directed(input logic [58:0] f);
        send_frame(f);
        n_directed++;
    endtask

    // Mostly well-formed frames with random content, then non-BCD field
    // content, single-bit corruption and plain noise.
    task automatic send_random(input int count);
        logic [58:0] f;
        int          kind;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(99);
            if (kind < 70)
                f = legal_frame();
            else if (kind < 80)
                f = make_frame(8'($urandom), 5'($urandom), 6'($urandom), 6'($urandom),
                               7'($urandom), 1'($urandom_range(1)), rand_bits());
            else if (kind < 90)
                f = legal_frame() ^ (59'd1 << $urandom_range(58));
            else
                f = rand_bits();
            send_frame(f);
        end
    endtask

    initial begin : stimulus
        logic [58:0] good;
        i_rst_n       <= 1'b0;
        i_frame_valid <= 1'b0;
        i_frame_bits  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corners, under the first pacing phase
        good = make_frame(8'h00, 5'h01, 6'h01, 6'h00, 7'h00, 1'b0, '0);
        send_directed('0);                                  // nothing set, day wraps
        send_directed({59{1'b1}});                          // every bit set
        send_directed(good);                                // the epoch itself
        send_directed(make_frame(8'h00, 5'h01, 6'h01, 6'h00, 7'h00, 1'b1, '0)); // CEST at epoch
        send_directed(make_frame(8'h00, 5'h01, 6'h00, 6'h00, 7'h00, 1'b0, '0)); // day zero
        send_directed(make_frame(8'h99, 5'h12, 6'h31, 6'h23, 7'h59, 1'b1, rand_bits()));
        send_directed(make_frame(8'hFF, 5'h1F, 6'h3F, 6'h3F, 7'h7F, 1'b0, {59{1'b1}}));
        send_directed(make_frame(8'h24, 5'h00, 6'h15, 6'h12, 7'h30, 1'b0, '0)); // month zero
        send_directed(make_frame(8'h23, 5'h13, 6'h01, 6'h00, 7'h00, 1'b0, '0)); // month 13
        send_directed(make_frame(8'h24, 5'h02, 6'h29, 6'h10, 7'h05, 1'b0, '0)); // leap day
        send_directed(make_frame(8'h23, 5'h03, 6'h01, 6'h10, 7'h05, 1'b1, '0));
        send_directed(make_frame(8'h0F, 5'h0F, 6'h0F, 6'h0F, 7'h0F, 1'b0, '0)); // non-BCD digits
        send_directed(good ^ (59'd1 << dcf_pkg::POS_START));  // start bit set
        send_directed(good ^ (59'd1 << dcf_pkg::POS_TSTART)); // time start marker missing
        send_directed(good ^ (59'd1 << dcf_pkg::POS_CET));    // neither CET nor CEST
        send_directed(good ^ (59'd1 << dcf_pkg::POS_CEST));   // both CET and CEST
        send_directed(good ^ (59'd1 << 28));                 // minute parity wrong
        send_directed(good ^ (59'd1 << 35));                 // hour parity wrong
        send_directed(good ^ (59'd1 << 58));                 // date parity wrong
        send_directed(good ^ (59'd1 << dcf_pkg::POS_YEAR));   // date group odd via data bit
        drain();

        // Phase 1: sender seldom idle, receiver mostly stalled
        send_random(PHASE_ITEMS);
        drain();

        // Phase 2: roles swapped
        tx_idle_pct  = 81;
        rx_stall_pct = 18;
        send_random(PHASE_ITEMS);
        drain();

        // Phase 3: full rate, opened by a long result hold so input backs up
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_req     = 1'b1;
        send_random(PHASE_ITEMS);
        drain();

        // A stray late result would still show up in this window
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Covered %0d frames (%0d directed corners) over three pacing phases",
                 n_sent, n_directed);
        $display("plus a %0d-cycle result hold at full input rate; %0d mismatches",
                 HOLD_CYCLES, chk_errors + chk_outstanding);
        if (chk_errors == 0 && chk_outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== dcf77_frame_decoder.f =====
src/dcf_pkg.sv
src/dcf_fields.sv
src/dcf_mac.sv
src/dcf77_frame_decoder.sv
tb/dcf77_decode_checker.sv
tb/tb_top.sv
